### src/assert_macros.svh
// Shared assertion macros for the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define MFPD_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define MFPD_ASSERT(label, prop, msg) \
    `MFPD_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

### src/mfpd_pkg.sv
package mfpd_pkg;

    // Frame limit and the derived widths.
    localparam int unsigned MAX_FRAME_BYTES = 512;
    localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned PSAT_W = CNT_W + 1;
    localparam int unsigned POS_W = CNT_W + 2;
    localparam int unsigned SIZE_CAP = MAX_FRAME_BYTES - 24;
    localparam int unsigned SIZE_W = 9;

    localparam logic [31:0] FRAME_HEADER = 32'h0000_55aa;
    localparam logic [31:0] FRAME_FOOTER = 32'h0000_aa55;
    localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
    localparam logic [31:0] CRC_XOROUT = 32'hffff_ffff;
    localparam logic [31:0] CRC_POLY = 32'hedb8_8320;

    // Result queue geometry.
    localparam int unsigned RQ_DEPTH = 4;
    localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef enum logic {
        KIND_PAYLOAD,
        KIND_STATUS
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_TRUNCATED,
        ST_BAD_HEADER,
        ST_LEN_SHORT,
        ST_CRC_ERROR,
        ST_BAD_FOOTER
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         payload_byte;
        logic [31:0]        sequence_res;
        logic [31:0]        command;
        logic [SIZE_W-1:0]  payload_size;
        status_t            status;
        logic               last_of_run;
    } res_t;

    // Results produced by one accepted byte: zero, one or two.
    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } res_push_t;

    // Reflected CRC-32 update by one byte.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### src/mfpd_parse.sv
`include "assert_macros.svh"

module mfpd_parse
    import mfpd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_accept,
    input  logic [7:0] in_byte,
    input  logic       in_eod,
    output res_push_t  push
);

    logic [CNT_W-1:0]  byte_count_reg, byte_count_next, count_upd;
    logic [31:0]       header_reg, header_next, header_upd;
    logic [31:0]       seq_reg, seq_next, seq_upd;
    logic [31:0]       cmd_reg, cmd_next, cmd_upd;
    logic [31:0]       len_reg, len_next, len_upd;
    logic [31:0]       crc_reg, crc_next, crc_upd;
    logic [31:0]       rx_crc_reg, rx_crc_next, rx_crc_upd;
    logic [31:0]       rx_ftr_reg, rx_ftr_next, rx_ftr_upd;

    logic              in_window;
    logic [31:0]       plen_cur;
    logic [PSAT_W-1:0] plen_sat;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  plen_x;
    logic              emit_payload;
    logic [31:0]       plen_upd;
    logic [31:0]       size_full;
    logic              short_frame;
    status_t           status_code;
    res_t              payload_res;
    res_t              status_res;

    // Per-byte field capture and CRC update.
    always_comb begin
        in_window  = byte_count_reg < CNT_W'(MAX_FRAME_BYTES);
        plen_cur   = (len_reg >= 32'd8) ? (len_reg - 32'd8) : 32'd0;
        // Payload lengths beyond the counter range behave the same as the largest one.
        plen_sat   = (plen_cur[31:CNT_W] != '0) ? {1'b1, {CNT_W{1'b0}}}
                                                : {1'b0, plen_cur[CNT_W-1:0]};
        pos_x      = POS_W'(byte_count_reg);
        plen_x     = POS_W'(plen_sat);

        count_upd    = byte_count_reg;
        header_upd   = header_reg;
        seq_upd      = seq_reg;
        cmd_upd      = cmd_reg;
        len_upd      = len_reg;
        crc_upd      = crc_reg;
        rx_crc_upd   = rx_crc_reg;
        rx_ftr_upd   = rx_ftr_reg;
        emit_payload = 1'b0;

        if (in_window) begin
            if (byte_count_reg < CNT_W'(4)) begin
                header_upd = {header_reg[23:0], in_byte};
            end else if (byte_count_reg < CNT_W'(8)) begin
                seq_upd = {seq_reg[23:0], in_byte};
            end else if (byte_count_reg < CNT_W'(12)) begin
                cmd_upd = {cmd_reg[23:0], in_byte};
            end else if (byte_count_reg < CNT_W'(16)) begin
                len_upd = {len_reg[23:0], in_byte};
            end

            if (pos_x < plen_x + POS_W'(16)) begin
                crc_upd      = crc32_byte(crc_reg, in_byte);
                emit_payload = byte_count_reg >= CNT_W'(16);
            end else if (pos_x < plen_x + POS_W'(20)) begin
                rx_crc_upd = {rx_crc_reg[23:0], in_byte};
            end else if (pos_x < plen_x + POS_W'(24)) begin
                rx_ftr_upd = {rx_ftr_reg[23:0], in_byte};
            end
            count_upd = byte_count_reg + CNT_W'(1);
        end
    end

    // Frame verdict, taken from the state as it stands after this byte.
    always_comb begin
        plen_upd  = (len_upd >= 32'd8) ? (len_upd - 32'd8) : 32'd0;
        size_full = (plen_upd > 32'(SIZE_CAP)) ? 32'(SIZE_CAP) : plen_upd;
        if (len_upd >= 32'd8) begin
            short_frame = 33'(count_upd) < (33'(len_upd) + 33'd16);
        end else begin
            short_frame = count_upd < CNT_W'(24);
        end

        if (short_frame) begin
            status_code = ST_TRUNCATED;
        end else if (header_upd != FRAME_HEADER) begin
            status_code = ST_BAD_HEADER;
        end else if (len_upd < 32'd8) begin
            status_code = ST_LEN_SHORT;
        end else if (rx_crc_upd != (crc_upd ^ CRC_XOROUT)) begin
            status_code = ST_CRC_ERROR;
        end else if (rx_ftr_upd != FRAME_FOOTER) begin
            status_code = ST_BAD_FOOTER;
        end else begin
            status_code = ST_OK;
        end

        payload_res              = '0;
        payload_res.kind         = KIND_PAYLOAD;
        payload_res.payload_byte = in_byte;
        payload_res.status       = ST_OK;
        payload_res.last_of_run  = !in_eod;

        status_res              = '0;
        status_res.kind         = KIND_STATUS;
        status_res.sequence_res = seq_upd;
        status_res.command      = cmd_upd;
        status_res.payload_size = size_full[SIZE_W-1:0];
        status_res.status       = status_code;
        status_res.last_of_run  = 1'b1;

        push.n  = in_accept ? (2'(emit_payload) + 2'(in_eod)) : 2'd0;
        push.r0 = emit_payload ? payload_res : status_res;
        push.r1 = status_res;
    end

    // The frame state is cleared at the end of every datagram.
    always_comb begin
        byte_count_next = byte_count_reg;
        header_next     = header_reg;
        seq_next        = seq_reg;
        cmd_next        = cmd_reg;
        len_next        = len_reg;
        crc_next        = crc_reg;
        rx_crc_next     = rx_crc_reg;
        rx_ftr_next     = rx_ftr_reg;
        if (in_accept) begin
            if (in_eod) begin
                byte_count_next = '0;
                header_next     = '0;
                seq_next        = '0;
                cmd_next        = '0;
                len_next        = '0;
                crc_next        = CRC_INIT;
                rx_crc_next     = '0;
                rx_ftr_next     = '0;
            end else begin
                byte_count_next = count_upd;
                header_next     = header_upd;
                seq_next        = seq_upd;
                cmd_next        = cmd_upd;
                len_next        = len_upd;
                crc_next        = crc_upd;
                rx_crc_next     = rx_crc_upd;
                rx_ftr_next     = rx_ftr_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            header_reg     <= '0;
            seq_reg        <= '0;
            cmd_reg        <= '0;
            len_reg        <= '0;
            crc_reg        <= CRC_INIT;
            rx_crc_reg     <= '0;
            rx_ftr_reg     <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
            header_reg     <= header_next;
            seq_reg        <= seq_next;
            cmd_reg        <= cmd_next;
            len_reg        <= len_next;
            crc_reg        <= crc_next;
            rx_crc_reg     <= rx_crc_next;
            rx_ftr_reg     <= rx_ftr_next;
        end
    end

    `MFPD_ASSERT(a_count_bounded, byte_count_reg <= CNT_W'(MAX_FRAME_BYTES), "byte count beyond frame limit")
    `MFPD_ASSERT(a_eod_clears, (in_accept && in_eod) |=> (byte_count_reg == '0 && crc_reg == CRC_INIT), "frame state not cleared after end of datagram")
    `MFPD_ASSERT(a_pair_order, (push.n == 2'd2) |-> (push.r0.kind == KIND_PAYLOAD && push.r1.kind == KIND_STATUS && !push.r0.last_of_run), "paired results out of order")

endmodule

### src/mfpd_res_fifo.sv
`include "assert_macros.svh"

module mfpd_res_fifo
    import mfpd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  res_push_t push,
    input  logic      pop,
    output res_t      head,
    output logic      not_empty,
    output logic      room_two
);

    res_t                mem_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RQ_CNT_W-1:0] count_reg, count_next;
    logic [RQ_PTR_W-1:0] wr_ptr_p1;
    logic                do_pop;

    always_comb begin
        do_pop      = pop && not_empty;
        wr_ptr_p1   = wr_ptr_reg + RQ_PTR_W'(1);
        wr_ptr_next = wr_ptr_reg + RQ_PTR_W'(push.n);
        rd_ptr_next = do_pop ? (rd_ptr_reg + RQ_PTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg + RQ_CNT_W'(push.n) - RQ_CNT_W'(do_pop);
    end

    assign not_empty = count_reg != '0;
    assign room_two  = count_reg <= RQ_CNT_W'(RQ_DEPTH - 2);
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            mem_reg[wr_ptr_p1] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `MFPD_ASSERT(a_count_limit, count_reg <= RQ_CNT_W'(RQ_DEPTH), "result queue count beyond depth")
    `MFPD_ASSERT(a_no_overflow, (push.n != 2'd0) |-> room_two, "results pushed without room")
    `MFPD_ASSERT(a_ptr_gap, (RQ_PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[RQ_PTR_W-1:0]), "queue pointers disagree with count")

endmodule

### src/magic_framed_packet_deframer_crc32_core.sv
// Deframer for CRC-32 checked frames, fed one datagram byte per request. A frame is the
// big-endian header word 0x000055aa, a sequence word, a command word and a length word L,
// then L-8 payload bytes, a big-endian reflected CRC-32 over everything before it, and the
// footer word 0x0000aa55. Every payload byte leaves as a result of kind 0, offered at the
// earliest in the cycle after it is taken; the byte flagged as end of datagram also
// produces a status result (kind 1) carrying the sequence and command words, the payload
// size saturated at SIZE_CAP (488) and a status code, and the frame state is then cleared
// for the next datagram. Bytes past the footer and bytes beyond the frame limit are
// dropped, but an end-of-datagram flag on them still closes the datagram. The block takes
// one byte per clock cycle: each byte is handled by a single pass of field capture, a
// byte-wide CRC update and the frame verdict between the state registers and a four-entry
// result queue. A byte yielding two results offers them on the output in turn, and s_ready
// is low while fewer than two queue entries are free. Such a byte always ends a
// datagram, and the sixteen header bytes of any frame yield no result, so with a receiver
// that is always ready the queue never holds more than two results and bytes are taken
// back to back at one per cycle without a stall; only a stalling receiver, letting three
// or more results build up, holds the input back.

module magic_framed_packet_deframer_crc32_core
    import mfpd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    // Byte request channel.
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_data_byte,
    input  logic              s_end_of_datagram,

    // Result request channel.
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_kind,
    output logic [7:0]        m_payload_byte,
    output logic [31:0]       m_sequence_res,
    output logic [31:0]       m_command,
    output logic [SIZE_W-1:0] m_payload_size,
    output logic [2:0]        m_status,
    output logic              m_last_of_run
);

    logic      in_accept;
    logic      room_two;
    res_push_t push;
    res_t      head;

    // A byte is taken only when the queue can hold both results it may produce.
    assign s_ready   = room_two;
    assign in_accept = s_valid && s_ready;

    // Frame parser: the state registers and the per-byte logic that produces results.
    mfpd_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_data_byte),
        .in_eod    (s_end_of_datagram),
        .push      (push)
    );

    // Result queue: decouples the two sides so that input keeps flowing while a result
    // waits to be taken.
    mfpd_res_fifo u_res_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (m_ready),
        .head      (head),
        .not_empty (m_valid),
        .room_two  (room_two)
    );

    assign m_kind         = head.kind;
    assign m_payload_byte = head.payload_byte;
    assign m_sequence_res = head.sequence_res;
    assign m_command      = head.command;
    assign m_payload_size = head.payload_size;
    assign m_status       = head.status;
    assign m_last_of_run  = head.last_of_run;

endmodule

### tb/sv/testbench.sv
module testbench;
    import mfpd_pkg::*;

    // Run limits. The slowest correct run (every byte answered with two results,
    // each waiting out a long receiver stall, plus the long hold-off) stays far
    // below the clock limit.
    localparam int CLOCK_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int DRAIN_CYCLES = 20;

    // Shapes of datagram; the random part draws from all but FR_MAXIMUM.
    typedef enum int {
        FR_GOOD,
        FR_BAD_HEADER,
        FR_SHORT_LEN,
        FR_BAD_CRC,
        FR_BAD_FOOTER,
        FR_TRUNCATED,
        FR_TRAILING,
        FR_HUGE_LEN,
        FR_NOISE,
        FR_MAXIMUM
    } flavour_t;

    // The scoreboard keeps its own copy of the frame state, works out the
    // results of every accepted byte request and holds them until the block
    // hands the matching result requests back.
    class deframe_scoreboard;
        res_t expected_results[$];
        int failures = 0;

        logic [15:0] seen_bytes;
        logic [31:0] header_word;
        logic [31:0] seq_word;
        logic [31:0] cmd_word;
        logic [31:0] len_word;
        logic [31:0] crc_acc;
        logic [31:0] crc_field;
        logic [31:0] footer_field;

        function new();
            clear_frame();
        endfunction

        function void clear_frame();
            seen_bytes = '0;
            header_word = '0;
            seq_word = '0;
            cmd_word = '0;
            len_word = '0;
            crc_acc = CRC_INIT;
            crc_field = '0;
            footer_field = '0;
        endfunction

        // Reflected CRC-32, one bit at a time.
        static function logic [31:0] crc_step(logic [31:0] acc, logic [7:0] b);
            logic [31:0] c;
            c = acc ^ {24'h0, b};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            return c;
        endfunction

        function void note_request(logic [7:0] b, logic eod);
            res_t made[$];
            res_t r;
            longint unsigned pos, plen, need, size;
            status_t st;
            if (seen_bytes < MAX_FRAME_BYTES) begin
                pos = seen_bytes;
                // The payload length is taken before this byte lands in a field.
                plen = (len_word >= 8) ? longint'(len_word) - 8 : 0;
                if (pos < 4)
                    header_word = {header_word[23:0], b};
                else if (pos < 8)
                    seq_word = {seq_word[23:0], b};
                else if (pos < 12)
                    cmd_word = {cmd_word[23:0], b};
                else if (pos < 16)
                    len_word = {len_word[23:0], b};

                if (pos < 16 + plen) begin
                    crc_acc = crc_step(crc_acc, b);
                    if (pos >= 16) begin
                        r = '0;
                        r.kind = KIND_PAYLOAD;
                        r.payload_byte = b;
                        made.push_back(r);
                    end
                end else if (pos < 20 + plen) begin
                    crc_field = {crc_field[23:0], b};
                end else if (pos < 24 + plen) begin
                    footer_field = {footer_field[23:0], b};
                end
                seen_bytes++;
            end

            if (eod) begin
                need = (len_word >= 8) ? longint'(len_word) + 16 : 24;
                size = (len_word >= 8) ? longint'(len_word) - 8 : 0;
                if (size > SIZE_CAP)
                    size = SIZE_CAP;
                // The checks are ranked: the first one that fails names the status.
                if (seen_bytes < need)
                    st = ST_TRUNCATED;
                else if (header_word != FRAME_HEADER)
                    st = ST_BAD_HEADER;
                else if (len_word < 8)
                    st = ST_LEN_SHORT;
                else if (crc_field != (crc_acc ^ CRC_XOROUT))
                    st = ST_CRC_ERROR;
                else if (footer_field != FRAME_FOOTER)
                    st = ST_BAD_FOOTER;
                else
                    st = ST_OK;
                r = '0;
                r.kind = KIND_STATUS;
                r.sequence_res = seq_word;
                r.command = cmd_word;
                r.payload_size = size[SIZE_W-1:0];
                r.status = st;
                made.push_back(r);
                clear_frame();
            end

            if (made.size() > 0)
                made[made.size()-1].last_of_run = 1'b1;
            foreach (made[i])
                expected_results.push_back(made[i]);
        endfunction

        function string describe(res_t r);
            return $sformatf("kind=%0d byte=%02h seq=%08h cmd=%08h size=%0d status=%0d last=%0b",
                             r.kind, r.payload_byte, r.sequence_res, r.command,
                             r.payload_size, r.status, r.last_of_run);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: %s", describe(got));
                return;
            end
            want = expected_results.pop_front();
            if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
                got.sequence_res !== want.sequence_res || got.command !== want.command ||
                got.payload_size !== want.payload_size || got.status !== want.status ||
                got.last_of_run !== want.last_of_run) begin
                failures++;
                if (failures <= 10)
                    $display("result mismatch\n  expected %s\n  actual   %s",
                             describe(want), describe(got));
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_data_byte = 8'h00;
    logic s_end_of_datagram = 1'b0;

    logic m_valid;
    logic m_ready = 1'b0;
    logic m_kind;
    logic [7:0] m_payload_byte;
    logic [31:0] m_sequence_res;
    logic [31:0] m_command;
    logic [SIZE_W-1:0] m_payload_size;
    logic [2:0] m_status;
    logic m_last_of_run;

    deframe_scoreboard sb = new();

    // Percentages of cycles in which the sender leaves valid low and in which
    // the receiver leaves ready low; the main sequence sets them per phase.
    int idle_pct = 0;
    int stall_pct = 0;

    // The main sequence asks for a long hold-off by bumping hold_requests; the
    // receiver process notices the difference and counts the stretch itself.
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    int cycle_count = 0;
    int items_sent = 0;
    logic [7:0] frame_bytes[$];

    magic_framed_packet_deframer_crc32_core uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_end_of_datagram (s_end_of_datagram),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_payload_byte    (m_payload_byte),
        .m_sequence_res    (m_sequence_res),
        .m_command         (m_command),
        .m_payload_size    (m_payload_size),
        .m_status          (m_status),
        .m_last_of_run     (m_last_of_run)
    );

    always #4 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CLOCK_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side. The values read here are those sampled at this edge, so a
    // result request counts as accepted when valid and ready were both high.
    always @(posedge aclk) begin : receive_results
        res_t got;
        if (aresetn && m_valid && m_ready) begin
            got.kind = kind_t'(m_kind);
            got.payload_byte = m_payload_byte;
            got.sequence_res = m_sequence_res;
            got.command = m_command;
            got.payload_size = m_payload_size;
            got.status = status_t'(m_status);
            got.last_of_run = m_last_of_run;
            sb.check_result(got);
        end
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void push_word(logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            frame_bytes.push_back(w[8*i +: 8]);
    endfunction

    // Appends the big-endian CRC over everything queued so far, then the footer.
    function automatic void append_crc_footer();
        logic [31:0] crc;
        crc = CRC_INIT;
        foreach (frame_bytes[i])
            crc = deframe_scoreboard::crc_step(crc, frame_bytes[i]);
        push_word(crc ^ CRC_XOROUT);
        push_word(FRAME_FOOTER);
    endfunction

    // Sequence and command words lean towards their extremes now and then.
    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(7);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hffff_ffff;
        return $urandom();
    endfunction

    function automatic flavour_t pick_flavour();
        int r;
        r = $urandom_range(99);
        if (r < 50) return FR_GOOD;
        if (r < 57) return FR_BAD_HEADER;
        if (r < 62) return FR_SHORT_LEN;
        if (r < 70) return FR_BAD_CRC;
        if (r < 76) return FR_BAD_FOOTER;
        if (r < 86) return FR_TRUNCATED;
        if (r < 92) return FR_TRAILING;
        if (r < 96) return FR_HUGE_LEN;
        return FR_NOISE;
    endfunction

    // Builds one datagram into frame_bytes: a well-formed frame with random
    // content, then the damage that the flavour calls for.
    function automatic void build_frame(flavour_t flav);
        logic [31:0] len;
        int plen;
        int cut;
        frame_bytes.delete();
        if (flav == FR_NOISE) begin
            repeat ($urandom_range(1, 30))
                frame_bytes.push_back(8'($urandom()));
            return;
        end
        plen = ($urandom_range(9) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16);
        if (flav == FR_MAXIMUM)
            plen = SIZE_CAP;
        len = plen + 8;
        if (flav == FR_SHORT_LEN) begin
            len = $urandom_range(0, 7);
            plen = 0;
        end
        if (flav == FR_HUGE_LEN)
            len = $urandom_range(32'hffff_ffff, MAX_FRAME_BYTES - 15);
        push_word(FRAME_HEADER);
        push_word(pick_word());
        push_word(pick_word());
        push_word(len);
        if (flav == FR_HUGE_LEN) begin
            // A length that no datagram can satisfy: a few payload bytes, then the end.
            repeat ($urandom_range(0, 20))
                frame_bytes.push_back(8'($urandom()));
            return;
        end
        repeat (plen)
            frame_bytes.push_back(8'($urandom()));
        append_crc_footer();
        case (flav)
            FR_BAD_HEADER:
                frame_bytes[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            FR_BAD_CRC:
                frame_bytes[16 + plen + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            FR_BAD_FOOTER:
                frame_bytes[20 + plen + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
            FR_TRUNCATED: begin
                cut = $urandom_range(1, frame_bytes.size() - 1);
                while (frame_bytes.size() > cut)
                    void'(frame_bytes.pop_back());
            end
            FR_TRAILING:
                repeat ($urandom_range(1, 6))
                    frame_bytes.push_back(8'($urandom()));
            FR_MAXIMUM:
                // These land beyond the frame limit and must be dropped.
                repeat (10)
                    frame_bytes.push_back(8'($urandom()));
            default: ;
        endcase
    endfunction

    // Offers one byte request, with a random gap first when the phase asks for
    // one, and holds it steady until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic eod);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_end_of_datagram <= eod;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_request(b, eod);
        items_sent++;
    endtask

    task automatic send_datagram();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    initial begin
        // Reset is held low from the start and released at a clock edge.
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: a one-byte datagram of all ones, which is far too
        // short, then the smallest valid frame with an empty payload and the
        // sequence and command words at opposite extremes.
        frame_bytes.delete();
        frame_bytes.push_back(8'hff);
        send_datagram();
        frame_bytes.delete();
        push_word(FRAME_HEADER);
        push_word(32'hffff_ffff);
        push_word(32'h0000_0000);
        push_word(32'd8);
        append_crc_footer();
        send_datagram();

        // Random part in four phases of idling and stalling. The first phase also carries a
        // frame of the largest size, with bytes past the frame limit, sent
        // while the receiver holds off for a long stretch so that the result
        // queue fills and the block has to stall its input.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 74; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 74; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            if (phase == 0) begin
                hold_requests++;
                build_frame(FR_MAXIMUM);
                send_datagram();
            end
            items_sent = 0;
            while (items_sent < ITEMS_PER_PHASE) begin
                build_frame(pick_flavour());
                send_datagram();
            end
        end

        s_valid <= 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        while (sb.expected_results.size() != 0)
            @(posedge aclk);
        // A little longer, so that any stray extra result is still caught.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.failures == 0 && sb.expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/mfpd_pkg.sv
src/mfpd_parse.sv
src/mfpd_res_fifo.sv
src/magic_framed_packet_deframer_crc32_core.sv
tb/sv/testbench.sv
